### rtl/core/vtir_pkg.sv
// Package: request and result types, command and register codes, flag masks.
`default_nettype none

package vtir_pkg;

  // Request commands
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Register map
  localparam logic [3:0] REG_PORT_B   = 4'd0;
  localparam logic [3:0] REG_PORT_A   = 4'd1;
  localparam logic [3:0] REG_DIR_B    = 4'd2;
  localparam logic [3:0] REG_DIR_A    = 4'd3;
  localparam logic [3:0] REG_T1_CL    = 4'd4;
  localparam logic [3:0] REG_T1_CH    = 4'd5;
  localparam logic [3:0] REG_T1_LL    = 4'd6;
  localparam logic [3:0] REG_T1_LH    = 4'd7;
  localparam logic [3:0] REG_T2_CL    = 4'd8;
  localparam logic [3:0] REG_T2_CH    = 4'd9;
  localparam logic [3:0] REG_SHIFT    = 4'd10;
  localparam logic [3:0] REG_ACR      = 4'd11;
  localparam logic [3:0] REG_PCR      = 4'd12;
  localparam logic [3:0] REG_IFR      = 4'd13;
  localparam logic [3:0] REG_IER      = 4'd14;
  localparam logic [3:0] REG_PORT_A_NH = 4'd15;

  // Interrupt flag bits (7-bit flag and enable registers)
  localparam logic [6:0] FLAG_SR  = 7'h04;
  localparam logic [6:0] FLAG_T2  = 7'h20;
  localparam logic [6:0] FLAG_T1  = 7'h40;
  localparam logic [6:0] IRQ_MASK = FLAG_SR | FLAG_T1;

  // Timer 1 mode field of the auxiliary control register
  localparam logic [7:0] T1_MODE_MASK = 8'hC0;
  localparam logic [7:0] T1_MODE_CONT = 8'h40;

  localparam logic [15:0] COUNT_ALL_ONES = 16'hFFFF;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] reg_index;
    logic [7:0] write_data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/vtir_in_reg.sv
// Input register: captures one request and holds it until the core takes it.
`default_nettype none

module vtir_in_reg
  import vtir_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire item_t in_item,
  input  wire logic  advance,
  output logic       stall,
  output logic       item_valid,
  output item_t      item
);

  logic load;

  // Load when empty or when the held request moves on this cycle
  assign load  = !item_valid || advance;
  assign stall = !load;

  // Hold the request and its valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

### rtl/core/vtir_regs.sv
// Register file and timers: decodes one request, updates state, forms the result.
`default_nettype none

module vtir_regs
  import vtir_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  fire,
  input  wire item_t item,
  output result_t    res
);

  logic [7:0]  port_b, port_a, dir_b, dir_a, shift_reg;
  logic [7:0]  aux_control, periph_control, port_a_nohs, t2_latch_low;
  logic [6:0]  int_flags, int_enables;
  logic [15:0] t1_latch, t1_count, t2_count;
  logic        t1_reload_armed;

  logic [7:0]  port_b_next, port_a_next, dir_b_next, dir_a_next, shift_reg_next;
  logic [7:0]  aux_control_next, periph_control_next, port_a_nohs_next;
  logic [7:0]  t2_latch_low_next;
  logic [6:0]  int_flags_next, int_enables_next;
  logic [15:0] t1_latch_next, t1_count_next, t2_count_next;
  logic        t1_reload_armed_next;
  logic [7:0]  rdata;
  logic        t1_hit;

  // Decode the request and compute the next state
  always_comb begin
    port_b_next          = port_b;
    port_a_next          = port_a;
    dir_b_next           = dir_b;
    dir_a_next           = dir_a;
    shift_reg_next       = shift_reg;
    aux_control_next     = aux_control;
    periph_control_next  = periph_control;
    port_a_nohs_next     = port_a_nohs;
    t2_latch_low_next    = t2_latch_low;
    int_flags_next       = int_flags;
    int_enables_next     = int_enables;
    t1_latch_next        = t1_latch;
    t1_count_next        = t1_count;
    t2_count_next        = t2_count;
    t1_reload_armed_next = t1_reload_armed;
    rdata                = 8'h00;
    t1_hit               = 1'b0;

    case (item.command)
      CMD_READ: begin
        case (item.reg_index)
          REG_PORT_B: rdata = port_b;
          REG_PORT_A: rdata = port_a;
          REG_DIR_B:  rdata = dir_b;
          REG_DIR_A:  rdata = dir_a;
          REG_T1_CL: begin
            rdata          = t1_count[7:0];
            int_flags_next = int_flags & ~FLAG_T1;
          end
          REG_T1_CH:  rdata = t1_count[15:8];
          REG_T1_LL:  rdata = t1_latch[7:0];
          REG_T1_LH:  rdata = t1_latch[15:8];
          REG_T2_CL: begin
            rdata          = t2_count[7:0];
            int_flags_next = int_flags & ~FLAG_T2;
          end
          REG_T2_CH:  rdata = t2_count[15:8];
          REG_SHIFT: begin
            rdata          = shift_reg;
            int_flags_next = int_flags & ~FLAG_SR;
          end
          REG_ACR:    rdata = aux_control;
          REG_PCR:    rdata = periph_control;
          REG_IFR:    rdata = {|(int_flags & int_enables), int_flags};
          REG_IER:    rdata = {1'b1, int_enables};
          default:    rdata = port_a_nohs;
        endcase
      end

      CMD_WRITE: begin
        case (item.reg_index)
          REG_PORT_B: port_b_next = item.write_data;
          REG_PORT_A: port_a_next = item.write_data;
          REG_DIR_B:  dir_b_next  = item.write_data;
          REG_DIR_A:  dir_a_next  = item.write_data;
          REG_T1_CL, REG_T1_LL: t1_latch_next = {t1_latch[15:8], item.write_data};
          REG_T1_CH: begin
            // Load the count from the full latch and restart the countdown
            t1_latch_next        = {item.write_data, t1_latch[7:0]};
            t1_count_next        = {item.write_data, t1_latch[7:0]};
            t1_reload_armed_next = 1'b0;
            int_flags_next       = int_flags & ~FLAG_T1;
          end
          REG_T1_LH: begin
            t1_latch_next  = {item.write_data, t1_latch[7:0]};
            int_flags_next = int_flags & ~FLAG_T1;
          end
          REG_T2_CL: begin
            t2_latch_low_next = item.write_data;
            t2_count_next     = {8'h00, item.write_data};
          end
          REG_T2_CH:  t2_count_next       = {item.write_data, t2_latch_low};
          REG_SHIFT:  shift_reg_next      = item.write_data;
          REG_ACR:    aux_control_next    = item.write_data;
          REG_PCR:    periph_control_next = item.write_data;
          REG_IFR:    int_flags_next      = int_flags & ~item.write_data[6:0];
          REG_IER: begin
            if (item.write_data[7]) begin
              int_enables_next = int_enables | item.write_data[6:0];
            end else begin
              int_enables_next = int_enables & ~item.write_data[6:0];
            end
          end
          default:    port_a_nohs_next = item.write_data;
        endcase
      end

      CMD_TICK: begin
        // Advance timer 1: count down, pass through all ones, then reload; count timer 2 down
        if (t1_reload_armed) begin
          t1_count_next        = t1_latch;
          t1_reload_armed_next = 1'b0;
          t1_hit               = (t1_latch == 16'h0000);
        end else if (t1_count == 16'h0000) begin
          t1_count_next        = COUNT_ALL_ONES;
          t1_reload_armed_next = 1'b1;
        end else begin
          t1_count_next = t1_count - 16'd1;
          t1_hit        = (t1_count == 16'd1);
        end
        if (t1_hit && ((aux_control & T1_MODE_MASK) == T1_MODE_CONT)) begin
          int_flags_next = int_flags | FLAG_T1;
        end
        t2_count_next = t2_count - 16'd1;
      end

      default: begin
      end
    endcase
  end

  assign res.read_data = rdata;
  assign res.irq       = |(int_flags_next & int_enables_next & IRQ_MASK);

  // Commit the state when the request moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      port_b          <= 8'h00;
      port_a          <= 8'h00;
      dir_b           <= 8'h00;
      dir_a           <= 8'h00;
      shift_reg       <= 8'h00;
      aux_control     <= 8'h00;
      periph_control  <= 8'h00;
      port_a_nohs     <= 8'h00;
      t2_latch_low    <= 8'h00;
      int_flags       <= 7'h00;
      int_enables     <= 7'h00;
      t1_latch        <= COUNT_ALL_ONES;
      t1_count        <= COUNT_ALL_ONES;
      t2_count        <= COUNT_ALL_ONES;
      t1_reload_armed <= 1'b0;
    end else if (fire) begin
      port_b          <= port_b_next;
      port_a          <= port_a_next;
      dir_b           <= dir_b_next;
      dir_a           <= dir_a_next;
      shift_reg       <= shift_reg_next;
      aux_control     <= aux_control_next;
      periph_control  <= periph_control_next;
      port_a_nohs     <= port_a_nohs_next;
      t2_latch_low    <= t2_latch_low_next;
      int_flags       <= int_flags_next;
      int_enables     <= int_enables_next;
      t1_latch        <= t1_latch_next;
      t1_count        <= t1_count_next;
      t2_count        <= t2_count_next;
      t1_reload_armed <= t1_reload_armed_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/vtir_out_reg.sv
// Result register: holds one result until the receiver takes it.
`default_nettype none

module vtir_out_reg
  import vtir_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t res,
  input  wire logic    out_stall,
  output logic         out_valid,
  output logic [7:0]   read_data,
  output logic         irq
);

  // Fill on load, drop once taken, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      read_data <= res.read_data;
      irq       <= res.irq;
    end
  end

endmodule

`default_nettype wire

### rtl/core/via_timer_interrupt_regs.sv
// Top level: 6522-style register block with two timers and interrupt flags.
//
// Requests arrive on the input channel (in_valid / in_stall) as a command
// (read, write or timer tick), a register number and a write byte. Each
// request gives exactly one result on the output channel (out_valid /
// out_stall): the byte read, or zero for a write or tick, and the level
// of the interrupt line after the request.
// A request taken at one clock edge is decoded from the input register
// in the next cycle and its result is loaded into the result register
// once it moves on; while the receiver does not stall, one request per
// cycle is sustained by the single decode-and-update stage.
// While the receiver stalls, the result register holds its contents and
// one more request waits in the input register; in_stall rises only when
// both are full.
// Synchronous reset empties both registers and returns every register to
// zero, the timer 1 latch and count and the timer 2 count to all ones.
`default_nettype none

module via_timer_interrupt_regs
  import vtir_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] command,
  input  wire logic [3:0] reg_index,
  input  wire logic [7:0] write_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      read_data,
  output logic            irq
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  result_t res;

  assign in_item.command    = command;
  assign in_item.reg_index  = reg_index;
  assign in_item.write_data = write_data;

  // Move the held request on when the result register is free or emptying
  assign advance = item_valid && (!out_valid || !out_stall);

  vtir_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .advance    (advance),
    .stall      (in_stall),
    .item_valid (item_valid),
    .item       (item)
  );

  vtir_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (item),
    .res  (res)
  );

  vtir_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .read_data (read_data),
    .irq       (irq)
  );

  // The input side stalls only when a request is held behind a full result
  a_stall_needs_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (item_valid && out_valid && out_stall))
    else $error("input stalled without a held request behind a full result");

  // A request that moves on shows up as a result in the next cycle
  a_advance_to_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("request advanced but no result presented");

  // A result that is stalled and no new request still holds its byte
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(read_data) && $stable(irq)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

### bench/via_timer_interrupt_regs_tb.sv
// Testbench: randomized register, timer and interrupt checks of via_timer_interrupt_regs.
`default_nettype none

module via_timer_interrupt_regs_tb;
  import vtir_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PRINT_LIMIT = 100;
  localparam int unsigned ITEMS_PER_PHASE = 360;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] command = CMD_READ;
  logic [3:0] reg_index = REG_PORT_B;
  logic [7:0] write_data = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] read_data;
  logic       irq;

  via_timer_interrupt_regs dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .reg_index  (reg_index),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data),
    .irq        (irq)
  );

  // Request stream and expected bus results
  item_t   queued_requests[$];
  result_t due_results[$];

  // Pacing of both channels, percent per cycle
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned error_count = 0;
  int unsigned reads_done = 0;
  int unsigned writes_done = 0;
  int unsigned ticks_done = 0;
  int unsigned unused_done = 0;
  int unsigned results_checked = 0;
  int unsigned irq_high_seen = 0;
  int unsigned quiet_cycles = 0;

  // Mirror of the register file and timers
  logic [7:0]  out_b, out_a, ddr_b, ddr_a, sr_byte, acr, pcr, ora_nh, t2_lat_lo;
  logic [6:0]  ifr, ier;
  logic [15:0] t1_lat, t1_cnt, t2_cnt;
  logic        t1_wrapped;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what);
    error_count++;
    // keep the log short when everything goes wrong
    if (error_count <= PRINT_LIMIT)
      $display("ERROR @%0t: %s", $time, what);
  endtask

  // Apply one request to the mirror and return the bus result it gives
  function automatic result_t predict_access(item_t rq);
    result_t r;
    logic    hit;
    r = '0;
    hit = 1'b0;
    case (rq.command)
      CMD_READ: begin
        case (rq.reg_index)
          REG_PORT_B: r.read_data = out_b;
          REG_PORT_A: r.read_data = out_a;
          REG_DIR_B:  r.read_data = ddr_b;
          REG_DIR_A:  r.read_data = ddr_a;
          REG_T1_CL: begin
            r.read_data = t1_cnt[7:0];
            ifr = ifr & ~FLAG_T1;
          end
          REG_T1_CH:  r.read_data = t1_cnt[15:8];
          REG_T1_LL:  r.read_data = t1_lat[7:0];
          REG_T1_LH:  r.read_data = t1_lat[15:8];
          REG_T2_CL: begin
            r.read_data = t2_cnt[7:0];
            ifr = ifr & ~FLAG_T2;
          end
          REG_T2_CH:  r.read_data = t2_cnt[15:8];
          REG_SHIFT: begin
            r.read_data = sr_byte;
            ifr = ifr & ~FLAG_SR;
          end
          REG_ACR:    r.read_data = acr;
          REG_PCR:    r.read_data = pcr;
          REG_IFR:    r.read_data = {|(ifr & ier), ifr};
          REG_IER:    r.read_data = {1'b1, ier};
          default:    r.read_data = ora_nh;
        endcase
      end
      CMD_WRITE: begin
        case (rq.reg_index)
          REG_PORT_B: out_b = rq.write_data;
          REG_PORT_A: out_a = rq.write_data;
          REG_DIR_B:  ddr_b = rq.write_data;
          REG_DIR_A:  ddr_a = rq.write_data;
          REG_T1_CL, REG_T1_LL: t1_lat[7:0] = rq.write_data;
          REG_T1_CH: begin
            // high byte loads the counter and disarms the reload
            t1_lat[15:8] = rq.write_data;
            ifr = ifr & ~FLAG_T1;
            t1_cnt = t1_lat;
            t1_wrapped = 1'b0;
          end
          REG_T1_LH: begin
            t1_lat[15:8] = rq.write_data;
            ifr = ifr & ~FLAG_T1;
          end
          REG_T2_CL: begin
            t2_lat_lo = rq.write_data;
            t2_cnt = {8'h00, rq.write_data};
          end
          REG_T2_CH:  t2_cnt = {rq.write_data, t2_lat_lo};
          REG_SHIFT:  sr_byte = rq.write_data;
          REG_ACR:    acr = rq.write_data;
          REG_PCR:    pcr = rq.write_data;
          REG_IFR:    ifr = ifr & ~rq.write_data[6:0];
          REG_IER: begin
            if (rq.write_data[7])
              ier = ier | rq.write_data[6:0];
            else
              ier = ier & ~rq.write_data[6:0];
          end
          default:    ora_nh = rq.write_data;
        endcase
      end
      CMD_TICK: begin
        // timer 1 passes 0 -> all ones -> latch; a zero latch counts as a hit
        if (t1_wrapped) begin
          t1_cnt = t1_lat;
          t1_wrapped = 1'b0;
          hit = (t1_cnt == 16'h0000);
        end else if (t1_cnt == 16'h0000) begin
          t1_cnt = COUNT_ALL_ONES;
          t1_wrapped = 1'b1;
        end else begin
          t1_cnt = t1_cnt - 16'd1;
          hit = (t1_cnt == 16'h0000);
        end
        if (hit && (acr & T1_MODE_MASK) == T1_MODE_CONT)
          ifr = ifr | FLAG_T1;
        t2_cnt = t2_cnt - 16'd1;
      end
      default: ;
    endcase
    r.irq = |(ifr & ier & IRQ_MASK);
    return r;
  endfunction

  task automatic queue_request(logic [1:0] cmd, logic [3:0] idx, logic [7:0] data);
    item_t rq;
    rq.command = cmd;
    rq.reg_index = idx;
    rq.write_data = data;
    queued_requests.push_back(rq);
  endtask

  // Program timer 1 with a short period and run it; returns requests queued
  task automatic queue_timer_burst(output int unsigned n);
    int unsigned steps;
    logic [7:0]  mode;
    n = 0;
    mode = ($urandom_range(3) == 0) ? 8'($urandom) : {2'b01, 6'($urandom)};
    queue_request(CMD_WRITE, REG_ACR, mode);
    n++;
    if ($urandom_range(1)) begin
      queue_request(CMD_WRITE, REG_IER, {$urandom_range(3) != 0, 7'($urandom)});
      n++;
    end
    queue_request(CMD_WRITE, $urandom_range(1) ? REG_T1_CL : REG_T1_LL,
                  8'($urandom_range(6)));
    queue_request(CMD_WRITE, REG_T1_CH, 8'h00);
    n += 2;
    steps = $urandom_range(3, 16);
    for (int unsigned i = 0; i < steps; i++) begin
      case ($urandom_range(9))
        0: queue_request(CMD_READ, REG_IFR, 8'($urandom));
        1: queue_request(CMD_READ, REG_T1_CL, 8'($urandom));
        2: queue_request(CMD_READ, $urandom_range(1) ? REG_T1_CH : REG_IER, 8'($urandom));
        3: queue_request(CMD_WRITE, REG_IFR, 8'($urandom));
        default: queue_request(CMD_TICK, 4'($urandom), 8'($urandom));
      endcase
      n++;
    end
  endtask

  // One free-form request; returns 0 when it is the ignored command
  task automatic queue_random_request(output int unsigned n);
    logic [1:0] cmd;
    if ($urandom_range(99) < 4) begin
      cmd = CMD_UNUSED;
    end else begin
      case ($urandom_range(2))
        0:       cmd = CMD_READ;
        1:       cmd = CMD_WRITE;
        default: cmd = CMD_TICK;
      endcase
    end
    queue_request(cmd, 4'($urandom), 8'($urandom));
    n = (cmd == CMD_UNUSED) ? 0 : 1;
  endtask

  // Drive requests, mirror each accepted one into the expected results
  always @(posedge clk) begin
    item_t nxt;
    item_t taken;
    if (rst) begin
      in_valid <= 1'b0;
      out_b = '0; out_a = '0; ddr_b = '0; ddr_a = '0; sr_byte = '0;
      acr = '0; pcr = '0; ora_nh = '0; t2_lat_lo = '0; ifr = '0; ier = '0;
      t1_lat = COUNT_ALL_ONES; t1_cnt = COUNT_ALL_ONES; t1_wrapped = 1'b0;
      t2_cnt = COUNT_ALL_ONES;
    end else begin
      if (in_valid && !in_stall) begin
        taken.command = command;
        taken.reg_index = reg_index;
        taken.write_data = write_data;
        due_results.push_back(predict_access(taken));
        case (command)
          CMD_READ:  reads_done++;
          CMD_WRITE: writes_done++;
          CMD_TICK:  ticks_done++;
          default:   unused_done++;
        endcase
      end
      // advance only when the slot is empty or just taken; hold while stalled
      if (!in_valid || !in_stall) begin
        if (queued_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = queued_requests.pop_front();
          in_valid <= 1'b1;
          command <= nxt.command;
          reg_index <= nxt.reg_index;
          write_data <= nxt.write_data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each delivered result against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result read_data=%02h irq=%0b",
                                    read_data, irq));
        end else begin
          want = due_results.pop_front();
          results_checked++;
          if (irq)
            irq_high_seen++;
          if (read_data !== want.read_data)
            report_mismatch($sformatf("read_data %02h, expected %02h",
                                      read_data, want.read_data));
          if (irq !== want.irq)
            report_mismatch($sformatf("irq %0b, expected %0b", irq, want.irq));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Drop the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned send_by_phase[4];
    int unsigned recv_by_phase[4];
    int unsigned counted;
    int unsigned n;

    send_by_phase = '{0, 57, 0, 36};
    recv_by_phase = '{0, 0, 57, 36};

    // Directed: ignored command, zero latch hit, all-ones load, timer 2, flags, shift, IER, port A
    queue_request(CMD_UNUSED, 4'hF, 8'hFF);
    queue_request(CMD_WRITE, REG_ACR, T1_MODE_CONT);
    queue_request(CMD_WRITE, REG_IER, 8'hFF);
    queue_request(CMD_WRITE, REG_T1_LL, 8'h00);
    queue_request(CMD_WRITE, REG_T1_CH, 8'h00);
    queue_request(CMD_TICK, 4'h0, 8'h00);
    queue_request(CMD_TICK, 4'hF, 8'hFF);
    queue_request(CMD_READ, REG_IFR, 8'h00);
    queue_request(CMD_READ, REG_T1_CL, 8'h00);
    queue_request(CMD_READ, REG_IFR, 8'h00);
    queue_request(CMD_WRITE, REG_T1_CL, 8'hFF);
    queue_request(CMD_WRITE, REG_T1_CH, 8'hFF);
    queue_request(CMD_TICK, 4'h0, 8'h00);
    queue_request(CMD_READ, REG_T1_CH, 8'h00);
    queue_request(CMD_WRITE, REG_T2_CL, 8'h01);
    queue_request(CMD_WRITE, REG_T2_CH, 8'h00);
    queue_request(CMD_TICK, 4'h0, 8'h00);
    queue_request(CMD_TICK, 4'h0, 8'h00);
    queue_request(CMD_READ, REG_T2_CL, 8'h00);
    queue_request(CMD_READ, REG_T2_CH, 8'h00);
    queue_request(CMD_WRITE, REG_SHIFT, 8'hFF);
    queue_request(CMD_READ, REG_SHIFT, 8'h00);
    queue_request(CMD_WRITE, REG_IER, 8'h7F);
    queue_request(CMD_READ, REG_IER, 8'h00);
    queue_request(CMD_READ, REG_PORT_A_NH, 8'h00);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Random requests under four pacing phases
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_by_phase[p];
      recv_stall_pct = recv_by_phase[p];
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 35)
          queue_timer_burst(n);
        else
          queue_random_request(n);
        counted += n;
      end
      while (queued_requests.size() > 0)
        @(posedge clk);
    end

    // Drain, then wait out any stray result before the final check
    while (queued_requests.size() > 0 || in_valid || due_results.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (due_results.size() > 0)
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));

    $display("Ran %0d reads, %0d writes, %0d ticks, %0d unused commands in four pacing phases",
             reads_done, writes_done, ticks_done, unused_done);
    $display("Checked %0d results, %0d with the interrupt line high, %0d errors",
             results_checked, irq_high_seen, error_count);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
